// ===== rtl/core/apto_pkg.sv =====
// ----------------------------------------------------------------------------
// apto_pkg
// Shared widths, constants and types of the alignment point tour optimizer.
// ----------------------------------------------------------------------------
`default_nettype none

package apto_pkg;

    localparam int DEFAULT_MAX_POINTS = 64;

    localparam int AZ_W       = 21;
    localparam int ALT_W      = 20;
    localparam int ST_W       = 17;
    localparam int DEC_W      = 20;
    localparam int PEN_W      = 20;
    localparam int HA_W       = 18;
    localparam int COST_W     = 23;
    localparam int ACC_W      = 26;
    localparam int VI_W       = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int AZ_HALF = 648000;
    localparam int AZ_FULL = 1296000;
    localparam int HA_HALF = 43200;
    localparam int HA_FULL = 86400;

    typedef struct packed {
        logic        [AZ_W-1:0]  az;
        logic signed [ALT_W-1:0] alt;
        logic        [ST_W-1:0]  ra;
        logic signed [DEC_W-1:0] dec;
    } t_coord;

    localparam int COORD_W = $bits(t_coord);

    typedef struct packed {
        logic             alt_az;
        logic [ST_W-1:0]  sidereal;
        logic [PEN_W-1:0] penalty;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALT_AZ_MODE   = 3'd0,
        REG_SIDEREAL_TIME = 3'd1,
        REG_FLIP_PENALTY  = 3'd2,
        REG_START_AZIMUTH = 3'd3,
        REG_START_ALT     = 3'd4,
        REG_START_RA      = 3'd5,
        REG_START_DEC     = 3'd6
    } t_reg_idx;

    typedef enum logic [5:0] {
        S_LOAD, S_NN_INIT, S_NN_I, S_NN_CMP,
        S_2_INIT, S_2_SCAN, S_2_I, S_2_IRD, S_2_J, S_2_JRD,
        S_2_C2, S_2_C3, S_2_C4, S_2_DEC, S_2_REV, S_2_RRD, S_2_W2,
        S_OR_INIT, S_OR_S, S_OR_SRD, S_OR_SRD2, S_OR_G2, S_OR_G3, S_OR_GDONE,
        S_OR_H, S_OR_HRD, S_OR_I2, S_OR_I3, S_OR_HDEC, S_OR_APPLY,
        S_MV, S_MV_W, S_LOOP_CHK, S_OUT_RD, S_OUT_LD, S_OUT_W,
        S_C1, S_C2, S_C3
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/apto_ram.sv =====
// ----------------------------------------------------------------------------
// apto_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module apto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    output logic      [WIDTH-1:0] o_rd_data_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    output logic      [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/apto_cost.sv =====
// ----------------------------------------------------------------------------
// apto_cost
// Two-stage Chebyshev move cost between two sky points.
// ----------------------------------------------------------------------------
`default_nettype none

module apto_cost import apto_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_cfg                      i_cfg,
    input  wire t_coord                    i_a,
    input  wire t_coord                    i_b,
    output logic signed [COST_W-1:0]       o_cost
);

    function automatic logic signed [HA_W-1:0] hour_angle(input logic [ST_W-1:0] st,
                                                          input logic [ST_W-1:0] ra);
        logic signed [HA_W-1:0] h;
        h = $signed({1'b0, st}) - $signed({1'b0, ra});
        // fold twice: covers the whole span of a 17-bit difference
        for (int k = 0; k < 2; k++) begin
            if (h > HA_HALF) begin
                h = HA_W'(h - HA_FULL);
            end else if (h < -HA_HALF) begin
                h = HA_W'(h + HA_FULL);
            end
        end
        return h;
    endfunction

    logic signed [AZ_W+1:0]  daz, daz_abs, caz;
    logic signed [ALT_W:0]   dalt;
    logic signed [DEC_W:0]   ddec;
    logic signed [HA_W-1:0]  ha_a, ha_b;
    logic                    flip;

    logic signed [AZ_W+1:0]  r_caz;
    logic signed [ALT_W:0]   r_dalt;
    logic signed [DEC_W:0]   r_ddec;
    logic signed [HA_W-1:0]  r_ha_a, r_ha_b;
    logic                    r_flip;

    logic signed [HA_W:0]    dha;
    logic signed [COST_W-1:0] m15, eq, aa, n_cost;

    always_comb begin
        daz     = $signed({2'b0, i_a.az}) - $signed({2'b0, i_b.az});
        daz_abs = (daz < 0) ? -daz : daz;
        caz     = (daz_abs > AZ_HALF) ? (AZ_W + 2)'(AZ_FULL - daz_abs) : daz_abs;
        dalt    = (ALT_W + 1)'(i_a.alt) - (ALT_W + 1)'(i_b.alt);
        dalt    = (dalt < 0) ? -dalt : dalt;
        ddec    = (DEC_W + 1)'(i_a.dec) - (DEC_W + 1)'(i_b.dec);
        ddec    = (ddec < 0) ? -ddec : ddec;
        ha_a    = hour_angle(i_cfg.sidereal, i_a.ra);
        ha_b    = hour_angle(i_cfg.sidereal, i_b.ra);
        flip    = (i_cfg.penalty != '0) &&
                  (((ha_a < 0) && (ha_b > 0)) || ((ha_a > 0) && (ha_b < 0)));
    end

    always_ff @(posedge i_clk) begin
        r_caz  <= caz;
        r_dalt <= dalt;
        r_ddec <= ddec;
        r_ha_a <= ha_a;
        r_ha_b <= ha_b;
        r_flip <= flip;
    end

    always_comb begin
        dha = (HA_W + 1)'(r_ha_a) - (HA_W + 1)'(r_ha_b);
        dha = (dha < 0) ? -dha : dha;
        m15 = (COST_W'(dha) <<< 4) - COST_W'(dha);
        eq  = (COST_W'(r_ddec) > m15) ? COST_W'(r_ddec) : m15;
        if (r_flip) begin
            eq = eq + COST_W'($signed({1'b0, i_cfg.penalty}));
        end
        aa  = (COST_W'(r_dalt) > COST_W'(r_caz)) ? COST_W'(r_dalt) : COST_W'(r_caz);
        n_cost = i_cfg.alt_az ? aa : eq;
    end

    always_ff @(posedge i_clk) begin
        o_cost <= n_cost;
    end

endmodule

`default_nettype wire

// ===== rtl/core/alignment_point_tour_optimizer.sv =====
// ----------------------------------------------------------------------------
// alignment_point_tour_optimizer
// Loads sky points, builds a nearest-neighbour tour from the start point,
// refines it with 2-opt and Or-opt, then streams the visiting order.
// ----------------------------------------------------------------------------
// Loading: one point beat per cycle, no result until the last-point flag.
// Optimization: every move cost runs through the registered cost unit in the
//   call states S_C1 to S_C3, tour table reads are registered, and the run time
//   follows the number of cost evaluations of the greedy, 2-opt and Or-opt passes.
// Output: one visit beat at a time, held until taken, the last one flagged.
// Reset (synchronous, active low): back to loading, point count and visited
//   marks zero, configuration registers zero; memories are not cleared.
`default_nettype none

module alignment_point_tour_optimizer import apto_pkg::*; #(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [AZ_W-1:0]          i_point_azimuth,
    input  wire logic signed [ALT_W-1:0]  i_point_altitude,
    input  wire logic [ST_W-1:0]          i_point_right_ascension,
    input  wire logic signed [DEC_W-1:0]  i_point_declination,
    input  wire logic                     i_last_point,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [VI_W-1:0]               o_visit_index,
    output logic                          o_last_visit
);

    // index width for the stores, count width for loop counters
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // a point id is either a stored point or the configured start point
    typedef struct packed {
        logic          st;
        logic [IW-1:0] ix;
    } t_pid;

    localparam t_pid START_ID = '{st: 1'b1, ix: '0};

    function automatic t_pid pt(input logic [IW-1:0] x);
        return '{st: 1'b0, ix: x};
    endfunction

    // ---------------- configuration registers ----------------
    logic                    r_alt_az;
    logic [ST_W-1:0]         r_sidereal;
    logic [PEN_W-1:0]        r_penalty;
    logic [AZ_W-1:0]         r_start_az;
    logic signed [ALT_W-1:0] r_start_alt;
    logic [ST_W-1:0]         r_start_ra;
    logic signed [DEC_W-1:0] r_start_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_az    <= 1'b0;
            r_sidereal  <= '0;
            r_penalty   <= '0;
            r_start_az  <= '0;
            r_start_alt <= '0;
            r_start_ra  <= '0;
            r_start_dec <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ALT_AZ_MODE:   r_alt_az    <= i_cfg_data[0];
                REG_SIDEREAL_TIME: r_sidereal  <= i_cfg_data[ST_W-1:0];
                REG_FLIP_PENALTY:  r_penalty   <= i_cfg_data[PEN_W-1:0];
                REG_START_AZIMUTH: r_start_az  <= i_cfg_data[AZ_W-1:0];
                REG_START_ALT:     r_start_alt <= i_cfg_data[ALT_W-1:0];
                REG_START_RA:      r_start_ra  <= i_cfg_data[ST_W-1:0];
                REG_START_DEC:     r_start_dec <= i_cfg_data[DEC_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    t_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_n, n_n, r_i, n_i, r_j, n_j, r_k, n_k, r_s, n_s, r_h, n_h;
    logic [CW-1:0] r_a, n_a, r_b, n_b, r_dst, n_dst;
    logic [IW-1:0] r_ra, n_ra, r_rb, n_rb;
    logic [IW-1:0] r_ti, n_ti, r_tj, n_tj, r_tj1, n_tj1, r_t0, n_t0;
    logic [IW-1:0] r_p, n_p, r_right, n_right, r_tb, n_tb, r_idx, n_idx;
    t_pid          r_ida, n_ida, r_idb, n_idb, r_prev, n_prev, r_cur, n_cur;
    t_pid          r_left, n_left, r_ta, n_ta;
    logic signed [ACC_W-1:0] r_acc, n_acc, r_best, n_best, r_gain, n_gain;
    logic          r_neg, n_neg, r_have, n_have, r_any2, n_any2, r_anyor, n_anyor;
    logic          r_up, n_up;
    logic [MAX_POINTS-1:0] r_vis, n_vis;
    logic          r_ovalid, n_ovalid, r_olast, n_olast;
    logic [IW-1:0] r_oidx, n_oidx;

    // memory ports
    logic          c_we, t_we;
    logic [IW-1:0] c_waddr, t_waddr, t_wdata;
    t_coord        c_wdata, c_rd_a, c_rd_b, start_coord, cost_a, cost_b;
    logic [IW-1:0] t_rd_a, t_rd_b;
    logic signed [COST_W-1:0] cost;
    t_cfg          cfg;
    logic          in_beat, out_beat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = r_ovalid && i_out_ready;

    assign cfg         = '{alt_az: r_alt_az, sidereal: r_sidereal, penalty: r_penalty};
    assign start_coord = '{az: r_start_az, alt: r_start_alt, ra: r_start_ra,
                           dec: r_start_dec};
    assign cost_a      = r_ida.st ? start_coord : c_rd_a;
    assign cost_b      = r_idb.st ? start_coord : c_rd_b;

    // point coordinates, read at both ends of a move at once
    apto_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_coord_ram (
        .i_clk       (i_clk),
        .i_wr_en     (c_we),
        .i_wr_addr   (c_waddr),
        .i_wr_data   (c_wdata),
        .i_rd_addr_a (n_ida.ix),
        .o_rd_data_a (c_rd_a),
        .i_rd_addr_b (n_idb.ix),
        .o_rd_data_b (c_rd_b)
    );

    // tour order
    apto_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_tour_ram (
        .i_clk       (i_clk),
        .i_wr_en     (t_we),
        .i_wr_addr   (t_waddr),
        .i_wr_data   (t_wdata),
        .i_rd_addr_a (n_ra),
        .o_rd_data_a (t_rd_a),
        .i_rd_addr_b (n_rb),
        .o_rd_data_b (t_rd_b)
    );

    apto_cost u_cost (
        .i_clk  (i_clk),
        .i_cfg  (cfg),
        .i_a    (cost_a),
        .i_b    (cost_b),
        .o_cost (cost)
    );

    // ---------------- next state and datapath ----------------
    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_n = r_n;  n_i = r_i;  n_j = r_j;  n_k = r_k;  n_s = r_s;  n_h = r_h;
        n_a = r_a;  n_b = r_b;  n_dst = r_dst;
        n_ra = r_ra;  n_rb = r_rb;
        n_ti = r_ti;  n_tj = r_tj;  n_tj1 = r_tj1;  n_t0 = r_t0;
        n_p = r_p;  n_right = r_right;  n_tb = r_tb;  n_idx = r_idx;
        n_ida = r_ida;  n_idb = r_idb;  n_prev = r_prev;  n_cur = r_cur;
        n_left = r_left;  n_ta = r_ta;
        n_acc = r_acc;  n_best = r_best;  n_gain = r_gain;
        n_neg = r_neg;  n_have = r_have;  n_any2 = r_any2;  n_anyor = r_anyor;
        n_up = r_up;  n_vis = r_vis;
        n_ovalid = r_ovalid;  n_olast = r_olast;  n_oidx = r_oidx;

        case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    if (r_n < CW'(MAX_POINTS)) begin
                        n_n = CW'(r_n + 1'b1);
                    end
                    if (i_last_point) begin
                        n_state = S_NN_INIT;
                    end
                end
            end

            // greedy chain, lowest index wins ties
            S_NN_INIT: begin
                n_vis  = '0;
                n_cur  = START_ID;
                n_k    = '0;
                n_i    = '0;
                n_have = 1'b0;
                n_state = S_NN_I;
            end
            S_NN_I: begin
                if (r_i == r_n) begin
                    n_vis[r_idx] = 1'b1;
                    n_cur = pt(r_idx);
                    if (CW'(r_k + 1'b1) == r_n) begin
                        n_state = S_2_INIT;
                    end else begin
                        n_k    = CW'(r_k + 1'b1);
                        n_i    = '0;
                        n_have = 1'b0;
                    end
                end else if (r_vis[IW'(r_i)]) begin
                    n_i = CW'(r_i + 1'b1);
                end else begin
                    n_acc = '0;
                    n_ida = r_cur;  n_idb = pt(IW'(r_i));
                    n_neg = 1'b0;   n_ret = S_NN_CMP;  n_state = S_C1;
                end
            end
            S_NN_CMP: begin
                if (!r_have || (r_acc < r_best)) begin
                    n_best = r_acc;
                    n_idx  = IW'(r_i);
                    n_have = 1'b1;
                end
                n_i = CW'(r_i + 1'b1);
                n_state = S_NN_I;
            end

            // first-improvement 2-opt
            S_2_INIT: begin
                n_any2  = 1'b0;
                n_state = S_2_SCAN;
            end
            S_2_SCAN: begin
                n_i = '0;
                n_state = S_2_I;
            end
            S_2_I: begin
                if (CW'(r_i + 1'b1) >= r_n) begin
                    n_state = S_OR_INIT;
                end else begin
                    n_ra = IW'(r_i - 1'b1);
                    n_rb = IW'(r_i);
                    n_state = S_2_IRD;
                end
            end
            S_2_IRD: begin
                n_prev  = (r_i == '0) ? START_ID : pt(t_rd_a);
                n_ti    = t_rd_b;
                n_j     = CW'(r_i + 1'b1);
                n_state = S_2_J;
            end
            S_2_J: begin
                if (r_j >= r_n) begin
                    n_i = CW'(r_i + 1'b1);
                    n_state = S_2_I;
                end else begin
                    n_ra = IW'(r_j);
                    n_rb = IW'(r_j + 1'b1);
                    n_state = S_2_JRD;
                end
            end
            S_2_JRD: begin
                n_tj  = t_rd_a;
                n_tj1 = t_rd_b;
                n_acc = '0;
                n_ida = r_prev;  n_idb = pt(r_ti);
                n_neg = 1'b0;    n_ret = S_2_C2;  n_state = S_C1;
            end
            S_2_C2: begin
                n_ida = r_prev;  n_idb = pt(r_tj);
                n_neg = 1'b1;    n_ret = S_2_C3;  n_state = S_C1;
            end
            S_2_C3: begin
                if (CW'(r_j + 1'b1) < r_n) begin
                    n_ida = pt(r_tj);  n_idb = pt(r_tj1);
                    n_neg = 1'b0;      n_ret = S_2_C4;  n_state = S_C1;
                end else begin
                    n_state = S_2_DEC;
                end
            end
            S_2_C4: begin
                n_ida = pt(r_ti);  n_idb = pt(r_tj1);
                n_neg = 1'b1;      n_ret = S_2_DEC;  n_state = S_C1;
            end
            S_2_DEC: begin
                if (r_acc > 0) begin
                    n_any2  = 1'b1;
                    n_a     = r_i;
                    n_b     = r_j;
                    n_state = S_2_REV;
                end else begin
                    n_j = CW'(r_j + 1'b1);
                    n_state = S_2_J;
                end
            end
            S_2_REV: begin
                if (r_a < r_b) begin
                    n_ra = IW'(r_a);
                    n_rb = IW'(r_b);
                    n_state = S_2_RRD;
                end else begin
                    n_state = S_2_SCAN;
                end
            end
            S_2_RRD: begin
                n_t0    = t_rd_a;
                n_state = S_2_W2;
            end
            S_2_W2: begin
                n_a = CW'(r_a + 1'b1);
                n_b = CW'(r_b - 1'b1);
                n_state = S_2_REV;
            end

            // best-move relocation of one point
            S_OR_INIT: begin
                n_anyor = 1'b0;
                n_s     = '0;
                n_state = (r_n < CW'(3)) ? S_LOOP_CHK : S_OR_S;
            end
            S_OR_S: begin
                if (r_s == r_n) begin
                    n_state = S_LOOP_CHK;
                end else begin
                    n_ra = IW'(r_s - 1'b1);
                    n_rb = IW'(r_s);
                    n_state = S_OR_SRD;
                end
            end
            S_OR_SRD: begin
                n_left  = (r_s == '0) ? START_ID : pt(t_rd_a);
                n_p     = t_rd_b;
                n_ra    = IW'(r_s + 1'b1);
                n_state = S_OR_SRD2;
            end
            S_OR_SRD2: begin
                n_right = t_rd_a;
                n_acc   = '0;
                n_ida = r_left;  n_idb = pt(r_p);
                n_neg = 1'b0;    n_ret = S_OR_G2;  n_state = S_C1;
            end
            S_OR_G2: begin
                if (CW'(r_s + 1'b1) < r_n) begin
                    n_ida = pt(r_p);  n_idb = pt(r_right);
                    n_neg = 1'b0;     n_ret = S_OR_G3;  n_state = S_C1;
                end else begin
                    n_state = S_OR_GDONE;
                end
            end
            S_OR_G3: begin
                n_ida = r_left;  n_idb = pt(r_right);
                n_neg = 1'b1;    n_ret = S_OR_GDONE;  n_state = S_C1;
            end
            S_OR_GDONE: begin
                n_gain  = r_acc;
                n_best  = '0;
                n_have  = 1'b0;
                n_h     = '0;
                n_state = S_OR_H;
            end
            S_OR_H: begin
                if (r_h == r_n) begin
                    n_state = S_OR_APPLY;
                end else if (r_h == r_s) begin
                    n_h = CW'(r_h + 1'b1);
                end else begin
                    // slots of the tour with the moved point taken out
                    n_ra = (r_h <= r_s) ? IW'(r_h - 1'b1) : IW'(r_h);
                    n_rb = (r_h < r_s) ? IW'(r_h) : IW'(r_h + 1'b1);
                    n_state = S_OR_HRD;
                end
            end
            S_OR_HRD: begin
                n_ta  = (r_h == '0) ? START_ID : pt(t_rd_a);
                n_tb  = t_rd_b;
                n_acc = r_gain;
                n_ida = (r_h == '0) ? START_ID : pt(t_rd_a);
                n_idb = pt(r_p);
                n_neg = 1'b1;  n_ret = S_OR_I2;  n_state = S_C1;
            end
            S_OR_I2: begin
                if (CW'(r_h + 1'b1) < r_n) begin
                    n_ida = pt(r_p);  n_idb = pt(r_tb);
                    n_neg = 1'b1;     n_ret = S_OR_I3;  n_state = S_C1;
                end else begin
                    n_state = S_OR_HDEC;
                end
            end
            S_OR_I3: begin
                n_ida = r_ta;  n_idb = pt(r_tb);
                n_neg = 1'b0;  n_ret = S_OR_HDEC;  n_state = S_C1;
            end
            S_OR_HDEC: begin
                if (r_acc > r_best) begin
                    n_best = r_acc;
                    n_dst  = r_h;
                    n_have = 1'b1;
                end
                n_h = CW'(r_h + 1'b1);
                n_state = S_OR_H;
            end
            S_OR_APPLY: begin
                if (!r_have) begin
                    n_s = CW'(r_s + 1'b1);
                    n_state = S_OR_S;
                end else begin
                    n_anyor = 1'b1;
                    n_k     = r_s;
                    n_up    = (r_dst > r_s);
                    n_state = S_MV;
                end
            end
            S_MV: begin
                if (r_k == r_dst) begin
                    n_s = '0;
                    n_state = S_OR_S;
                end else begin
                    n_ra = r_up ? IW'(r_k + 1'b1) : IW'(r_k - 1'b1);
                    n_state = S_MV_W;
                end
            end
            S_MV_W: begin
                n_k = r_up ? CW'(r_k + 1'b1) : CW'(r_k - 1'b1);
                n_state = S_MV;
            end

            S_LOOP_CHK: begin
                if (r_any2 || r_anyor) begin
                    n_state = S_2_INIT;
                end else begin
                    n_k = '0;
                    n_state = S_OUT_RD;
                end
            end

            // stream the tour
            S_OUT_RD: begin
                n_ra = IW'(r_k);
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_oidx   = t_rd_a;
                n_olast  = (CW'(r_k + 1'b1) == r_n);
                n_ovalid = 1'b1;
                n_state  = S_OUT_W;
            end
            S_OUT_W: begin
                if (out_beat) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_n   = '0;
                        n_vis = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k = CW'(r_k + 1'b1);
                        n_state = S_OUT_RD;
                    end
                end
            end

            // shared cost call: coordinates read, two unit stages, accumulate
            S_C1: n_state = S_C2;
            S_C2: n_state = S_C3;
            S_C3: begin
                n_acc   = r_neg ? ACC_W'(r_acc - ACC_W'(cost)) : ACC_W'(r_acc + ACC_W'(cost));
                n_state = r_ret;
            end

            default: n_state = S_LOAD;
        endcase
    end

    // ---------------- outputs and memory writes ----------------
    always_comb begin
        o_in_ready = (r_state == S_LOAD);
        c_we    = i_in_valid && (r_state == S_LOAD) && (r_n < CW'(MAX_POINTS));
        c_waddr = IW'(r_n);
        c_wdata = '{az: i_point_azimuth, alt: i_point_altitude,
                    ra: i_point_right_ascension, dec: i_point_declination};
        t_we    = 1'b0;
        t_waddr = IW'(r_k);
        t_wdata = t_rd_a;
        case (r_state)
            S_NN_I: begin
                t_we    = (r_i == r_n);
                t_waddr = IW'(r_k);
                t_wdata = r_idx;
            end
            S_2_RRD: begin
                t_we    = 1'b1;
                t_waddr = IW'(r_a);
                t_wdata = t_rd_b;
            end
            S_2_W2: begin
                t_we    = 1'b1;
                t_waddr = IW'(r_b);
                t_wdata = r_t0;
            end
            S_MV: begin
                t_we    = (r_k == r_dst);
                t_waddr = IW'(r_dst);
                t_wdata = r_p;
            end
            S_MV_W: begin
                t_we    = 1'b1;
                t_waddr = IW'(r_k);
                t_wdata = t_rd_a;
            end
            default: ;
        endcase
        o_out_valid   = r_ovalid;
        o_visit_index = VI_W'(r_oidx);
        o_last_visit  = r_olast;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_n      <= '0;
            r_vis    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_vis    <= n_vis;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_i <= n_i;  r_j <= n_j;  r_k <= n_k;  r_s <= n_s;  r_h <= n_h;
        r_a <= n_a;  r_b <= n_b;  r_dst <= n_dst;
        r_ra <= n_ra;  r_rb <= n_rb;
        r_ti <= n_ti;  r_tj <= n_tj;  r_tj1 <= n_tj1;  r_t0 <= n_t0;
        r_p <= n_p;  r_right <= n_right;  r_tb <= n_tb;  r_idx <= n_idx;
        r_ida <= n_ida;  r_idb <= n_idb;  r_prev <= n_prev;  r_cur <= n_cur;
        r_left <= n_left;  r_ta <= n_ta;
        r_acc <= n_acc;  r_best <= n_best;  r_gain <= n_gain;
        r_neg <= n_neg;  r_have <= n_have;  r_any2 <= n_any2;  r_anyor <= n_anyor;
        r_up <= n_up;
        r_olast <= n_olast;  r_oidx <= n_oidx;
    end

endmodule

`default_nettype wire

// ===== rtl/core/apto_checker.sv =====
// ----------------------------------------------------------------------------
// apto_checker
// Port-level checks of the tour optimizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apto_checker import apto_pkg::*; (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire logic            i_last_point,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire logic [VI_W-1:0] o_visit_index,
    input wire logic            o_last_visit
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_visit_index) && $stable(o_last_visit))
        else $error("result beat changed while stalled");

    // loading and streaming never overlap
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // the last point closes the input side
    a_last_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_point |=> !o_in_ready)
        else $error("still ready after the last point");

    // the final visit reopens loading
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_visit |=> o_in_ready && !o_out_valid)
        else $error("not back to loading after the last visit");

endmodule

bind alignment_point_tour_optimizer apto_checker u_apto_checker (.*);

`default_nettype wire

// ===== tb/alignment_point_tour_optimizer_tb.sv =====
// ----------------------------------------------------------------------------
// alignment_point_tour_optimizer_tb
// Self-checking bench: streams point sets into the tour optimizer, predicts
// each visiting order (greedy chain, 2-opt, Or-opt) and compares every visit
// beat, under bursty input, a stalling receiver and several register setups.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module alignment_point_tour_optimizer_tb;
    import apto_pkg::*;

    localparam int CAPACITY   = DEFAULT_MAX_POINTS;
    localparam int START_SLOT = CAPACITY;
    localparam int ITEM_GOAL  = 300;
    localparam int SETTLE     = 24;       // cycles after the last visit before a reg write
    localparam int LONG_HOLD  = 4000;     // receiver hold-off length
    localparam int IDLE_LIMIT = 2000000;  // cycles without any beat before giving up

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [AZ_W-1:0]         i_point_azimuth = '0;
    logic signed [ALT_W-1:0] i_point_altitude = '0;
    logic [ST_W-1:0]         i_point_right_ascension = '0;
    logic signed [DEC_W-1:0] i_point_declination = '0;
    logic                    i_last_point = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [VI_W-1:0]         o_visit_index;
    logic                    o_last_visit;

    alignment_point_tour_optimizer dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_point_azimuth        (i_point_azimuth),
        .i_point_altitude       (i_point_altitude),
        .i_point_right_ascension(i_point_right_ascension),
        .i_point_declination    (i_point_declination),
        .i_last_point           (i_last_point),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_visit_index          (o_visit_index),
        .o_last_visit           (o_last_visit)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Directed stimulus table. A row flagged "ident" closes a set whose tour
    // is plainly the load order (single point sets here), so its visits are
    // typed in instead of predicted.
    // ------------------------------------------------------------------
    typedef struct {
        int az;
        int alt;
        int ra;
        int dec;
        bit last;
        int setup;   // register setup the row runs under
        bit ident;
    } t_dir_row;

    localparam int DIR_ROWS = 19;
    t_dir_row dir_rows [DIR_ROWS] = '{
        // reset setup: equatorial, everything zero
        '{1295999,  324000, 86399,  324000, 1, 0, 1},   // all fields at max
        '{0,       -324000,     0, -324000, 1, 0, 1},   // all fields at min
        '{10000,    1000,    3600,    5000, 0, 0, 0},
        '{20000,   -1000,   82800,   -5000, 0, 0, 0},
        '{30000,    2000,   43200,   20000, 0, 0, 0},
        '{40000,   -2000,    7200,  -20000, 1, 0, 0},
        // equatorial extremes: max sidereal time and penalty
        '{0,            0,  86000,  100000, 0, 2, 0},
        '{0,            0,     10, -100000, 0, 2, 0},
        '{0,            0,  86399,       0, 0, 2, 0},
        '{0,            0,  43199,  324000, 0, 2, 0},
        '{0,            0,  43200, -324000, 1, 2, 0},
        // out-of-range raw codes in every field
        '{2097151, -524288, 131071,  524287, 1, 2, 1},
        // alt-az with the start at max azimuth: exercise the azimuth wrap
        '{1000,    -300000, 0, 0, 0, 1, 0},
        '{1295000,  300000, 0, 0, 0, 1, 0},
        '{648000,        0, 0, 0, 0, 1, 0},
        '{648001,    10000, 0, 0, 0, 1, 0},
        '{5,       -324000, 0, 0, 1, 1, 0},
        '{1296000,       0, 0, 0, 0, 1, 0},
        '{0,       -524288, 0, 0, 1, 1, 0}
    };

    // ------------------------------------------------------------------
    // Predictor state: register shadow and point stores (start in last slot)
    // ------------------------------------------------------------------
    typedef struct {
        logic [VI_W-1:0] idx;
        logic            last;
    } t_visit;

    t_visit                visit_q[$];          // visits still owed by the DUT
    logic [CFG_DATA_W-1:0] reg_shadow [7];
    longint                st_az  [CAPACITY+1];
    longint                st_alt [CAPACITY+1];
    longint                st_ra  [CAPACITY+1];
    longint                st_dec [CAPACITY+1];
    int                    tour   [CAPACITY];
    int                    held_points = 0;

    int  items_sent = 0;
    int  burst_left = 0;
    int  mismatches = 0;
    bit  failed = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  mode_left = 0;
    int  rx_mode = 0;
    int  cycle_cnt = 0;
    int  idle_cycles = 0;

    // Append one owed visit at the tail of the queue
    function automatic void queue_visit(int idx, bit last);
        t_visit v;
        v.idx  = VI_W'(idx);
        v.last = last;
        visit_q.insert(visit_q.size(), v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint hour_angle(longint ra);
        longint h;
        h = longint'(reg_shadow[REG_SIDEREAL_TIME][ST_W-1:0]) - ra;
        while (h > HA_HALF) h -= HA_FULL;
        while (h < -HA_HALF) h += HA_FULL;
        return h;
    endfunction

    function automatic longint move_cost(int a, int b);
        longint c, t, ha, hb, pen;
        if (reg_shadow[REG_ALT_AZ_MODE][0]) begin
            c = mag(st_az[a] - st_az[b]);
            if (c > AZ_HALF) c = AZ_FULL - c;
            t = mag(st_alt[a] - st_alt[b]);
            return c > t ? c : t;
        end
        ha  = hour_angle(st_ra[a]);
        hb  = hour_angle(st_ra[b]);
        pen = longint'(reg_shadow[REG_FLIP_PENALTY][PEN_W-1:0]);
        c   = mag(ha - hb) * 15;
        t   = mag(st_dec[a] - st_dec[b]);
        if (t > c) c = t;
        if (pen > 0 && ((ha < 0 && hb > 0) || (ha > 0 && hb < 0))) c += pen;
        return c;
    endfunction

    // First-improvement segment reversal; rescan from the top after each move
    function automatic bit reverse_pass(int n);
        bit     any, found;
        int     prev, a, b, tmp;
        longint cur, swp;
        any   = 1'b0;
        found = 1'b1;
        while (found) begin
            found = 1'b0;
            for (int i = 0; i < n - 1 && !found; i++) begin
                prev = (i == 0) ? START_SLOT : tour[i-1];
                for (int j = i + 1; j < n && !found; j++) begin
                    cur = move_cost(prev, tour[i]);
                    swp = move_cost(prev, tour[j]);
                    if (j < n - 1) begin
                        cur += move_cost(tour[j], tour[j+1]);
                        swp += move_cost(tour[i], tour[j+1]);
                    end
                    if (cur - swp > 0) begin
                        a = i;
                        b = j;
                        while (a < b) begin
                            tmp     = tour[a];
                            tour[a] = tour[b];
                            tour[b] = tmp;
                            a++;
                            b--;
                        end
                        found = 1'b1;
                        any   = 1'b1;
                    end
                end
            end
        end
        return any;
    endfunction

    // Position r of the tour with slot s taken out; -1 is the start point
    function automatic int slot_without(int r, int s);
        if (r < 0) return START_SLOT;
        return tour[r < s ? r : r + 1];
    endfunction

    // Best-move relocation of a single point; restart from the head on a move
    function automatic bit relocate_pass(int n);
        bit     any, have;
        int     s, p, left, best_g, a, dst;
        longint gain, ins, best;
        any = 1'b0;
        if (n < 3) return 1'b0;
        s = 0;
        while (s < n) begin
            p    = tour[s];
            left = (s > 0) ? tour[s-1] : START_SLOT;
            if (s < n - 1)
                gain = move_cost(left, p) + move_cost(p, tour[s+1]) - move_cost(left, tour[s+1]);
            else
                gain = move_cost(left, p);
            best   = 0;
            have   = 1'b0;
            best_g = 0;
            for (int g = -1; g <= n - 2; g++) begin
                if (g == s - 1) continue;
                a = slot_without(g, s);
                if (g < n - 2)
                    ins = move_cost(a, p) + move_cost(p, slot_without(g + 1, s))
                          - move_cost(a, slot_without(g + 1, s));
                else
                    ins = move_cost(a, p);
                if (gain - ins > best) begin
                    best   = gain - ins;
                    best_g = g;
                    have   = 1'b1;
                end
            end
            if (have) begin
                dst = best_g + 1;
                for (int k = s; k < n - 1; k++) tour[k] = tour[k+1];
                for (int k = n - 1; k > dst; k--) tour[k] = tour[k-1];
                tour[dst] = p;
                any = 1'b1;
                s   = 0;
            end else begin
                s++;
            end
        end
        return any;
    endfunction

    // Store one accepted point beat; on the last one, queue the tour visits.
    // With ident set the tour is the load order, so skip the search.
    task automatic plan_tour(t_coord c, bit last, bit ident);
        int     n, cur, pick;
        longint best, d;
        bit     seen [CAPACITY];
        bit     moved_a, moved_b;
        if (held_points < CAPACITY) begin
            st_az[held_points]  = longint'(c.az);
            st_alt[held_points] = longint'(c.alt);
            st_ra[held_points]  = longint'(c.ra);
            st_dec[held_points] = longint'(c.dec);
            held_points++;
        end
        if (!last) return;
        n = held_points;
        held_points = 0;
        if (ident) begin
            for (int k = 0; k < n; k++) queue_visit(k, k == n - 1);
            return;
        end
        st_az[START_SLOT]  = longint'(reg_shadow[REG_START_AZIMUTH][AZ_W-1:0]);
        st_alt[START_SLOT] = longint'($signed(reg_shadow[REG_START_ALT][ALT_W-1:0]));
        st_ra[START_SLOT]  = longint'(reg_shadow[REG_START_RA][ST_W-1:0]);
        st_dec[START_SLOT] = longint'($signed(reg_shadow[REG_START_DEC][DEC_W-1:0]));
        // greedy chain, lowest index wins ties
        foreach (seen[i]) seen[i] = 1'b0;
        cur = START_SLOT;
        for (int k = 0; k < n; k++) begin
            pick = -1;
            best = 0;
            for (int i = 0; i < n; i++) begin
                if (seen[i]) continue;
                d = move_cost(cur, i);
                if (pick < 0 || d < best) begin
                    best = d;
                    pick = i;
                end
            end
            tour[k]    = pick;
            seen[pick] = 1'b1;
            cur        = pick;
        end
        do begin
            moved_a = reverse_pass(n);
            moved_b = relocate_pass(n);
        end while (moved_a || moved_b);
        for (int k = 0; k < n; k++) queue_visit(tour[k], k == n - 1);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int signed_in(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_coord rand_point();
        t_coord c;
        case ($urandom_range(0, 7))
            0: begin // raw codes, out of range allowed
                c.az  = AZ_W'($urandom);
                c.alt = ALT_W'($urandom);
                c.ra  = ST_W'($urandom);
                c.dec = DEC_W'($urandom);
            end
            1, 2: begin // coarse grid: ties, wrap edges and hour-angle sign flips
                c.az  = AZ_W'($urandom_range(0, 4) * 324000);
                c.alt = ALT_W'(($urandom_range(0, 4) - 2) * 162000);
                c.ra  = ST_W'($urandom_range(0, 4) * 21600);
                c.dec = DEC_W'(($urandom_range(0, 4) - 2) * 162000);
            end
            default: begin
                c.az  = AZ_W'($urandom_range(0, 1295999));
                c.alt = ALT_W'(signed_in(324000));
                c.ra  = ST_W'($urandom_range(0, 86399));
                c.dec = DEC_W'(signed_in(324000));
            end
        endcase
        return c;
    endfunction

    // Random register value: mostly in range, now and then an end or a raw code
    function automatic logic [CFG_DATA_W-1:0] rand_reg(int lo, int hi);
        case ($urandom_range(0, 7))
            0: return CFG_DATA_W'(lo);
            1: return CFG_DATA_W'(hi);
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'(int'($urandom_range(0, hi - lo)) + lo);
        endcase
    endfunction

    // Write one register at the next edge; the caller lowers the enable
    task automatic write_reg(t_reg_idx r, logic [CFG_DATA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        reg_shadow[r] = v;
    endtask

    // Drop valid, wait until every owed visit is out, then let the core settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (visit_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setups: 0 reset values, 1 alt-az extremes, 2 equatorial extremes, 3 random
    task automatic apply_setup(int setup);
        drain();
        case (setup)
            0: begin
                write_reg(REG_ALT_AZ_MODE, '0);
                write_reg(REG_SIDEREAL_TIME, '0);
                write_reg(REG_FLIP_PENALTY, '0);
                write_reg(REG_START_AZIMUTH, '0);
                write_reg(REG_START_ALT, '0);
                write_reg(REG_START_RA, '0);
                write_reg(REG_START_DEC, '0);
            end
            1: begin
                write_reg(REG_ALT_AZ_MODE, CFG_DATA_W'(1));
                write_reg(REG_SIDEREAL_TIME, '0);
                write_reg(REG_FLIP_PENALTY, '0);
                write_reg(REG_START_AZIMUTH, CFG_DATA_W'(1295999));
                write_reg(REG_START_ALT, CFG_DATA_W'(-324000));
                write_reg(REG_START_RA, CFG_DATA_W'(86399));
                write_reg(REG_START_DEC, CFG_DATA_W'(-324000));
            end
            2: begin
                write_reg(REG_ALT_AZ_MODE, '0);
                write_reg(REG_SIDEREAL_TIME, CFG_DATA_W'(86399));
                write_reg(REG_FLIP_PENALTY, CFG_DATA_W'(648000));
                write_reg(REG_START_AZIMUTH, '0);
                write_reg(REG_START_ALT, CFG_DATA_W'(324000));
                write_reg(REG_START_RA, '0);
                write_reg(REG_START_DEC, CFG_DATA_W'(324000));
            end
            default: begin
                write_reg(REG_ALT_AZ_MODE, CFG_DATA_W'($urandom_range(0, 1)));
                write_reg(REG_SIDEREAL_TIME, rand_reg(0, 86399));
                write_reg(REG_FLIP_PENALTY,
                          ($urandom_range(0, 3) == 0) ? '0 : rand_reg(0, 648000));
                write_reg(REG_START_AZIMUTH, rand_reg(0, 1295999));
                write_reg(REG_START_ALT, rand_reg(-324000, 324000));
                write_reg(REG_START_RA, rand_reg(0, 86399));
                write_reg(REG_START_DEC, rand_reg(-324000, 324000));
            end
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one point beat and hold it until accepted. Called at an edge;
    // the sender idles between bursts of random length.
    task automatic send_point(t_coord c, bit last, bit ident);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid              <= 1'b1;
        i_point_azimuth         <= c.az;
        i_point_altitude        <= c.alt;
        i_point_right_ascension <= c.ra;
        i_point_declination     <= c.dec;
        i_last_point            <= last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        plan_tour(c, last, ident);
    endtask

    task automatic send_set(int n);
        for (int k = 0; k < n; k++) send_point(rand_point(), k == n - 1, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own plus the long hold-off, and check
    // every visit beat against the oldest owed visit.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (o_out_valid && i_out_ready) begin
            if (visit_q.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected visit beat idx=%0d last=%0b",
                             $realtime, o_visit_index, o_last_visit);
            end else begin
                t_visit want;
                want = visit_q.pop_front();
                if (o_visit_index !== want.idx || o_last_visit !== want.last) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] visit mismatch: expected idx=%0d last=%0b, got idx=%0d last=%0b",
                                 $realtime, want.idx, want.last, o_visit_index, o_last_visit);
                end
            end
        end
        if (hold_req && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (cycle_cnt % 5) != 0;
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int     setup_now;
        int     set_cnt;
        t_coord same_pt;
        setup_now = -1;
        set_cnt   = 0;
        foreach (reg_shadow[i]) reg_shadow[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; switch register setup only between sets
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].setup != setup_now) begin
                setup_now = dir_rows[r].setup;
                apply_setup(setup_now);
            end
            send_point('{AZ_W'(dir_rows[r].az), ALT_W'(dir_rows[r].alt),
                         ST_W'(dir_rows[r].ra), DEC_W'(dir_rows[r].dec)},
                       dir_rows[r].last, dir_rows[r].ident);
        end

        // capacity overflow: identical points cost nothing between them, so
        // the tour is the load order; the two extra beats are dropped, the
        // flag on the last dropped one still starts the run
        same_pt = '{AZ_W'(777), ALT_W'(-4321), ST_W'(12345), DEC_W'(-9876)};
        for (int k = 0; k < CAPACITY + 2; k++)
            send_point(same_pt, k == CAPACITY + 1, k == CAPACITY + 1);

        // the block fills up: hold the receiver while two sets are offered
        apply_setup(3);
        hold_req = 1'b1;
        send_set(5);
        send_set(5);

        // random sets, mostly small, with register changes and full drains
        while (items_sent < ITEM_GOAL) begin
            set_cnt++;
            if ($urandom_range(0, 3) == 0)
                apply_setup(3);
            else if ($urandom_range(0, 5) == 0)
                drain();
            send_set(($urandom_range(0, 9) == 0) ? $urandom_range(12, 20)
                                                 : $urandom_range(1, 8));
        end

        drain();
        if (failed || visit_q.size() != 0)
            $display("*** FAILED ***");
        else
            $display("*** PASSED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/apto_pkg.sv
rtl/core/apto_ram.sv
rtl/core/apto_cost.sv
rtl/core/alignment_point_tour_optimizer.sv
rtl/core/apto_checker.sv
tb/alignment_point_tour_optimizer_tb.sv
